### hw/rtl/asd_pkg.sv
// Package for the adaptive step descent core: widths, ops and fixed-point helpers.
// No dependencies.
package asd_pkg;
    localparam int MaxShellsDef = 256;
    localparam int AxesDef = 3;
    localparam int PosW = 32;
    localparam int StepW = 32;
    localparam int ShellW = 8;

    localparam logic OP_DESCENT = 1'b0;
    localparam logic OP_SHRINK  = 1'b1;

    // floor(v/5) for v below 2^35; estimate is low by at most one, then corrected
    function automatic logic [33:0] f_div5(input logic [34:0] v);
        logic [70:0] p;
        p = 71'(v) * 71'd6871947673;
        return 34'(p >> 35) + 34'((v - 35'((p >> 35) * 5)) >= 35'd5);
    endfunction

    // floor(s*6/5), saturated to 32 bits
    function automatic logic [31:0] f_grow(input logic [31:0] s);
        logic [33:0] q;
        q = f_div5(35'(s) * 35'd6);
        if (q > 34'hFFFFFFFF) return 32'hFFFFFFFF;
        return q[31:0];
    endfunction
endpackage

### hw/rtl/asd_divider.sv
// Radix-2 restoring divider: k = (ux << 24) / uf, saturated to 32 bits.
// Depends on asd_pkg.
module asd_divider
    import asd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    localparam int QW = 57;
    logic [QW-1:0] r_num;
    logic [33:0]   r_rem;
    logic [32:0]   r_den;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic [33:0]   n_rem;

    always_comb begin
        n_rem = {r_rem[32:0], r_num[QW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_num  <= {i_num, 24'd0};
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= 6'(QW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (n_rem >= {1'b0, r_den}) begin
                    r_rem <= n_rem - {1'b0, r_den};
                    r_num <= {r_num[QW-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_num <= {r_num[QW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = (r_num[QW-1:32] != '0) ? 32'hFFFFFFFF : r_num[31:0];
endmodule

### hw/rtl/asd_axis_unit.sv
// Per-axis step adaptation and position update, sequenced by the top level.
// Depends on asd_pkg and asd_divider.
module asd_axis_unit
    import asd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_first,
    input  logic [31:0]       i_init,
    input  logic signed [31:0] i_pos,
    input  logic signed [31:0] i_force,
    input  logic signed [31:0] i_prev_pos,
    input  logic signed [31:0] i_prev_force,
    input  logic [31:0]       i_step,
    output logic              o_done,
    output logic [31:0]       o_step,
    output logic signed [31:0] o_new
);
    typedef enum logic [2:0] {S_IDLE, S_DIV, S_ADAPT, S_MUL, S_ADD} t_state;
    t_state r_state;
    logic signed [32:0] r_dx, r_df;
    logic [31:0] r_step, r_k;
    logic [63:0] r_mag;
    logic div_start, div_done;
    logic [31:0] div_q;
    logic [32:0] ux, uf;
    logic [31:0] n_step;
    logic signed [41:0] d, sum;

    assign ux = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign uf = r_df[32] ? 33'(-r_df) : 33'(r_df);
    assign div_start = (r_state == S_DIV) && !o_done && r_dx != 0 && r_df != 0
                       && (r_dx[32] != r_df[32]) && r_k == 32'hFFFF_FFFE;

    asd_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(ux), .i_den(uf), .o_done(div_done), .o_quot(div_q)
    );

    always_comb begin
        if (r_dx != 0 && r_df != 0) begin
            if ({1'b0, r_k} >= {r_step, 1'b0}) n_step = f_grow(r_step);
            else if (r_k == 0) n_step = 32'(f_div5(35'(r_step) << 2));
            else n_step = 32'(f_div5((35'(r_step) << 2) + 35'(r_k)));
        end else if (r_dx != 0) begin
            n_step = f_grow(r_step);
        end else begin
            n_step = r_step;
        end
    end

    assign d = i_force[31] ? -42'((r_mag + 64'hFFFFFF) >> 24) : 42'(r_mag >> 24);
    assign sum = 42'(i_pos) + d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_dx   <= 33'(i_pos) - 33'(i_prev_pos);
                    r_df   <= 33'(i_force) - 33'(i_prev_force);
                    r_step <= i_first ? i_init : i_step;
                    r_k    <= 32'hFFFF_FFFE;
                    r_state <= i_first ? S_MUL : S_DIV;
                end
                S_DIV: begin
                    if (r_dx == 0 || r_df == 0 || r_dx[32] == r_df[32]) begin
                        r_k <= '0;
                        r_state <= S_ADAPT;
                    end else if (div_done) begin
                        r_k <= div_q;
                        r_state <= S_ADAPT;
                    end else if (div_start) begin
                        r_k <= 32'hFFFF_FFFD;
                    end
                end
                S_ADAPT: begin
                    r_step  <= n_step;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_mag <= 64'($unsigned(i_force[31] ? -i_force : i_force)) * 64'(r_step);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (sum > 42'sh7FFFFFFF) o_new <= 32'h7FFFFFFF;
                    else if (sum < -42'sh80000000) o_new <= 32'h80000000;
                    else o_new <= sum[31:0];
                    o_step  <= r_step;
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/adaptive_step_descent_core.sv
// Top level of the adaptive step descent core: state memories and sequencer.
// Depends on asd_pkg and asd_axis_unit.
//
// Input channel i_valid/o_ready carries one descent or shrink beat per shell.
// Output channel o_valid/i_ready carries one trial position per descent beat.
// Each shell has per-axis previous position, previous force and step held in
// one memory word per shell, read through a registered output.
// A descent beat runs read, one 57-step serial divider per axis (all axes in
// parallel, only for axes with nonzero position and force deltas of opposite
// sign), adapt, multiply, add, write back. A first-iteration beat skips the
// divider. A shrink beat scales each step by 4/5. One beat is worked at a
// time, which also removes any read-after-write hazard on the memory.
// The result waits in an output register; the next beat is accepted while it
// waits, but its result is held back until the register is taken.
// Reset clears the sequencer and output valid; the memories are not cleared
// and a shell must see a first-iteration beat before it is adapted or shrunk.
// Shell indexes at or above MAX_SHELLS are consumed with no effect.
module adaptive_step_descent_core
    import asd_pkg::*;
#(
    parameter int MAX_SHELLS = MaxShellsDef,
    parameter int AXES = AxesDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [7:0]         i_shell_index,
    input  logic               i_first_iteration,
    input  logic [31:0]        i_initial_step,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_force_x,
    input  logic signed [31:0] i_force_y,
    input  logic signed [31:0] i_force_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_out_shell,
    output logic signed [31:0] o_new_x,
    output logic signed [31:0] o_new_y,
    output logic signed [31:0] o_new_z
);
    localparam int AW = (MAX_SHELLS > 1) ? $clog2(MAX_SHELLS) : 1;
    localparam int WW = AXES * 96;
    typedef enum logic [2:0] {S_IDLE, S_READ, S_RUN, S_WAIT, S_SHR, S_OUT} t_state;
    t_state r_state;

    logic [WW-1:0] mem [MAX_SHELLS];
    logic [WW-1:0] r_rd, r_wd;
    logic [AW-1:0] r_addr;
    logic r_we;
    logic r_op, r_first;
    logic [7:0] r_shell;
    logic [31:0] r_init;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_frc [3];
    logic signed [31:0] r_new [3];
    logic [AXES-1:0] ax_done;
    logic [31:0] ax_step [AXES];
    logic signed [31:0] ax_new [AXES];
    logic [AXES-1:0] r_got;
    logic in_range;

    assign in_range = 32'(i_shell_index) < 32'(MAX_SHELLS);
    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_addr] <= r_wd;
        r_rd <= mem[r_addr];
    end

    genvar g;
    generate
        for (g = 0; g < AXES; g++) begin : g_ax
            asd_axis_unit u_ax (
                .i_clk(i_clk), .i_rst_n(i_rst_n),
                .i_start(r_state == S_RUN), .i_first(r_first), .i_init(r_init),
                .i_pos(r_pos[g]), .i_force(r_frc[g]),
                .i_prev_pos(r_rd[g*96 +: 32]), .i_prev_force(r_rd[g*96+32 +: 32]),
                .i_step(r_rd[g*96+64 +: 32]),
                .o_done(ax_done[g]), .o_step(ax_step[g]), .o_new(ax_new[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_we    <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && in_range) begin
                    r_addr  <= AW'(i_shell_index);
                    r_op    <= i_op;
                    r_first <= i_first_iteration;
                    r_shell <= i_shell_index;
                    r_init  <= i_initial_step;
                    r_pos   <= '{i_pos_x, i_pos_y, i_pos_z};
                    r_frc   <= '{i_force_x, i_force_y, i_force_z};
                    r_got   <= '0;
                    r_state <= S_READ;
                end
                S_READ: r_state <= (r_op == OP_SHRINK) ? S_SHR : S_RUN;
                S_RUN: r_state <= S_WAIT;
                S_SHR: begin
                    r_wd <= r_rd;
                    for (int a = 0; a < AXES; a++)
                        r_wd[a*96+64 +: 32] <=
                            32'(f_div5(35'(r_rd[a*96+64 +: 32]) << 2));
                    r_we <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_WAIT: begin
                    for (int a = 0; a < AXES; a++) begin
                        if (ax_done[a]) begin
                            r_wd[a*96 +: 96] <= {ax_step[a], r_frc[a], r_pos[a]};
                            r_new[a] <= ax_new[a];
                        end
                    end
                    for (int a = AXES; a < 3; a++) r_new[a] <= r_pos[a];
                    if ((r_got | ax_done) == {AXES{1'b1}}) begin
                        r_we <= 1'b1;
                        r_state <= S_OUT;
                    end
                    r_got <= r_got | ax_done;
                end
                S_OUT: if (!o_valid || i_ready) begin
                    o_valid     <= 1'b1;
                    o_out_shell <= r_shell;
                    o_new_x     <= r_new[0];
                    o_new_y     <= r_new[1];
                    o_new_z     <= r_new[2];
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### test/adaptive_step_descent_core_tb.sv
// Testbench for adaptive_step_descent_core: drives descent and shrink beats under
// random idling and stalls; checks every trial position against an in-bench model.
// Depends on asd_pkg and the core RTL.
module adaptive_step_descent_core_tb;
    import asd_pkg::*;

    localparam int NSHELL = 256;
    localparam int NAX = 3;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic [7:0]  shell;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
    } trial_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_op;
    logic [7:0]  i_shell_index;
    logic        i_first_iteration;
    logic [31:0] i_initial_step;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [31:0] i_force_x, i_force_y, i_force_z;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_out_shell;
    logic signed [31:0] o_new_x, o_new_y, o_new_z;

    int errors;
    longint cycles = 0;
    int send_idle_pct;
    int recv_stall_pct;
    bit loaded [NSHELL];
    logic [31:0] hist_pos [NSHELL][NAX];
    logic [31:0] hist_force [NSHELL][NAX];

    adaptive_step_descent_core uut (.*);

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    class descent_scoreboard;
        logic [31:0] prev_pos [NSHELL][NAX];
        logic [31:0] prev_frc [NSHELL][NAX];
        logic [31:0] step [NSHELL][NAX];
        trial_t pending [$];

        function logic [31:0] grow_step(logic [31:0] s);
            logic [35:0] g;
            g = (36'(s) * 6) / 5;
            return (g > 36'hFFFFFFFF) ? 32'hFFFFFFFF : g[31:0];
        endfunction

        function logic [31:0] shrink_step(logic [31:0] s);
            return 32'((36'(s) * 4) / 5);
        endfunction

        function logic [31:0] adapt_step(logic [31:0] s, longint dx, longint df);
            logic [63:0] ux;
            logic [63:0] uf;
            logic [63:0] k;
            if (dx != 0 && df != 0) begin
                ux = (dx < 0) ? -dx : dx;
                uf = (df < 0) ? -df : df;
                k = 0;
                if ((dx < 0) != (df < 0)) begin
                    k = (ux << 24) / uf;
                    if (k > 64'hFFFFFFFF) k = 64'hFFFFFFFF;
                end
                if (k >= 2 * 64'(s)) return grow_step(s);
                if (k == 0) return shrink_step(s);
                return 32'((4 * 64'(s) + k) / 5);
            end
            if (dx != 0) return grow_step(s);
            return s;
        endfunction

        function logic [31:0] move_axis(longint p, longint f, logic [31:0] s);
            logic [63:0] mag;
            longint d;
            longint r;
            mag = 64'((f < 0) ? -f : f) * 64'(s);
            if (f >= 0) d = longint'(mag >> 24);
            else d = -longint'((mag + 64'hFFFFFF) >> 24);
            r = p + d;
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            return r[31:0];
        endfunction

        function void note_input(logic op, logic [7:0] sh, logic first, logic [31:0] init,
                                 logic [31:0] pos [NAX], logic [31:0] frc [NAX]);
            trial_t t;
            logic [31:0] res [NAX];
            longint p;
            longint f;
            if (sh >= NSHELL) return;
            if (op == OP_SHRINK) begin
                for (int a = 0; a < NAX; a++) step[sh][a] = shrink_step(step[sh][a]);
                return;
            end
            for (int a = 0; a < NAX; a++) begin
                p = longint'(signed'(pos[a]));
                f = longint'(signed'(frc[a]));
                if (first) step[sh][a] = init;
                else step[sh][a] = adapt_step(step[sh][a],
                    p - longint'(signed'(prev_pos[sh][a])),
                    f - longint'(signed'(prev_frc[sh][a])));
                prev_pos[sh][a] = pos[a];
                prev_frc[sh][a] = frc[a];
                res[a] = move_axis(p, f, step[sh][a]);
            end
            t.shell = sh;
            t.nx = res[0];
            t.ny = res[1];
            t.nz = res[2];
            pending.push_back(t);
        endfunction

        task check_result(logic [7:0] sh, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z);
            trial_t t;
            if (pending.size() == 0) begin
                report_mismatch("unexpected beat shell", 32'(sh), 32'hx);
                return;
            end
            t = pending.pop_front();
            if (sh !== t.shell) report_mismatch("out_shell", 32'(sh), 32'(t.shell));
            if (x !== t.nx) report_mismatch("new_x", x, t.nx);
            if (y !== t.ny) report_mismatch("new_y", y, t.ny);
            if (z !== t.nz) report_mismatch("new_z", z, t.nz);
        endtask
    endclass

    descent_scoreboard sb;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_out_shell, o_new_x, o_new_y, o_new_z);
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if (recv_stall_pct == 0) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_beat(input logic op, input logic [7:0] sh, input logic first,
                             input logic [31:0] init, input logic [31:0] pos [NAX],
                             input logic [31:0] frc [NAX]);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_shell_index <= sh;
        i_first_iteration <= first;
        i_initial_step <= init;
        i_pos_x <= pos[0];
        i_pos_y <= pos[1];
        i_pos_z <= pos[2];
        i_force_x <= frc[0];
        i_force_y <= frc[1];
        i_force_z <= frc[2];
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(op, sh, first, init, pos, frc);
        if (op == OP_DESCENT) begin
            loaded[sh] = loaded[sh] | first;
            hist_pos[sh] = pos;
            hist_force[sh] = frc;
        end
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 255) - 128;
            3: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rnd_step();
        case ($urandom_range(4))
            0: return 32'hFFFFFFFF;
            1: return 32'h0;
            2: return $urandom_range(32'h0100_0000, 32'h0010_0000);
            default: return $urandom;
        endcase
    endfunction

    // Random descent or shrink beat; adapted beats often reuse or nudge the
    // shell's last position/force so each axis rule is reached.
    task automatic random_beat();
        logic [31:0] pos [NAX];
        logic [31:0] frc [NAX];
        logic [7:0] sh;
        logic first;
        logic op;
        sh = (($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15)));
        first = !loaded[sh] || ($urandom_range(9) == 0);
        op = (!first && $urandom_range(9) == 0) ? OP_SHRINK : OP_DESCENT;
        for (int a = 0; a < NAX; a++) begin
            if (first || $urandom_range(3) == 0) begin
                pos[a] = rnd_word();
                frc[a] = rnd_word();
            end else begin
                pos[a] = hist_pos[sh][a] + (($urandom_range(2) == 0) ? 0
                         : $urandom_range(0, 32'h40000) - 32'h20000);
                frc[a] = hist_force[sh][a] + (($urandom_range(2) == 0) ? 0
                         : $urandom_range(0, 32'h40000) - 32'h20000);
            end
        end
        send_beat(op, sh, first, rnd_step(), pos, frc);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] pos [NAX];
        logic [31:0] frc [NAX];
        sb = new();
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = OP_DESCENT;
        i_shell_index = '0;
        i_first_iteration = 1'b0;
        i_initial_step = '0;
        {i_pos_x, i_pos_y, i_pos_z, i_force_x, i_force_y, i_force_z} = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, both ops, every adapt rule
        pos = '{32'h7FFFFFFF, 32'h80000000, 32'h0};
        frc = '{32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF};
        send_beat(OP_DESCENT, 8'd255, 1'b1, 32'hFFFFFFFF, pos, frc);
        send_beat(OP_DESCENT, 8'd0, 1'b1, 32'h0, pos, frc);
        pos = '{32'h00010000, 32'hFFFF0000, 32'h0};
        frc = '{32'hFFFF0000, 32'h00010000, 32'h00008000};
        send_beat(OP_DESCENT, 8'd1, 1'b1, 32'h0100_0000, pos, frc);
        send_beat(OP_DESCENT, 8'd1, 1'b0, 32'h0, pos, frc);
        pos = '{32'h00020000, 32'hFFFE0000, 32'h00010000};
        frc = '{32'hFFFE8000, 32'h00020000, 32'h00008000};
        send_beat(OP_DESCENT, 8'd1, 1'b0, 32'h0, pos, frc);
        pos = '{32'h00030000, 32'hFFFD0000, 32'h00020000};
        frc = '{32'hFFFD0000, 32'h00030000, 32'h00004000};
        send_beat(OP_DESCENT, 8'd1, 1'b0, 32'h0, pos, frc);
        pos = '{32'h00030001, 32'hFFFD0000, 32'h00020000};
        frc = '{32'hFFFD0000, 32'h00040000, 32'h00004000};
        send_beat(OP_DESCENT, 8'd1, 1'b0, 32'h0, pos, frc);
        send_beat(OP_SHRINK, 8'd1, 1'b0, 32'h0, pos, frc);
        send_beat(OP_SHRINK, 8'd255, 1'b0, 32'hFFFFFFFF, pos, frc);
        pos = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000};
        frc = '{32'h7FFFFFFF, 32'h80000000, 32'h80000000};
        send_beat(OP_DESCENT, 8'd255, 1'b0, 32'h0, pos, frc);
        send_beat(OP_DESCENT, 8'd0, 1'b0, 32'hFFFFFFFF, pos, frc);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 86) : 0;
            recv_stall_pct = (ph == 2) ? 86 : ((ph == 3) ? 22 : 0);
            for (int n = 0; n < 200; n++) random_beat();
            wait_drained();
        end

        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/asd_pkg.sv
hw/rtl/asd_divider.sv
hw/rtl/asd_axis_unit.sv
hw/rtl/adaptive_step_descent_core.sv
test/adaptive_step_descent_core_tb.sv
